FILE: hdl/wavhp_pkg.sv
package wavhp_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] audio_format;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [31:0] data_offset;
      logic [31:0] riff_size;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RIFF_ID   = 4'd1,
      PH_RIFF_SIZE = 4'd2,
      PH_WAVE_ID   = 4'd3,
      PH_CHUNK_ID  = 4'd4,
      PH_CHUNK_SZ  = 4'd5,
      PH_FMT_TAG   = 4'd6,
      PH_CHANNELS  = 4'd7,
      PH_RATE      = 4'd8,
      PH_BYTERATE  = 4'd9,
      PH_ALIGN     = 4'd10,
      PH_BITS      = 4'd11,
      PH_CBSIZE    = 4'd12,
      PH_SKIP      = 4'd13
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_RIFF  = 3'd1,
      ST_NO_WAVE  = 3'd2,
      ST_NO_DATA  = 3'd3,
      ST_TRUNC    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_FMT   = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } step_stat_type;

   localparam logic [31:0] TAG_RIFF      = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
   localparam logic [15:0] FMT_PCM       = 16'h0001;
   localparam logic [15:0] FMT_EXT       = 16'hFFFE;
   localparam logic [31:0] FMT_FIXED_LEN = 32'd16;
   localparam logic [31:0] EXT_SKIP      = 32'd22;
   localparam logic [32:0] RIFF_HDR_LEN  = 33'd8;

   // bytes in the field read during each phase
   function automatic logic [2:0] field_len(input phase_type ph);
      logic [2:0] n;
      case (ph)
         PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_ID, PH_CHUNK_ID, PH_CHUNK_SZ,
         PH_RATE, PH_BYTERATE:                            n = 3'd4;
         PH_FMT_TAG, PH_CHANNELS, PH_ALIGN, PH_BITS,
         PH_CBSIZE:                                       n = 3'd2;
         default:                                         n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: hdl/wav_header_parser_core.sv
// A byte is registered on input and its result, if any, is registered on
// output, with rsp_valid, once the byte leaves the input register. One byte per
// cycle while no result is held untaken; the parse state updates once per byte.
// Reset: synchronous, active high; clears the valid flags and leaves the parser
// idle until a byte marked first arrives.
module wav_header_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wavhp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wavhp_pkg::rsp_type rsp_data
);

   logic                     item_valid;
   wavhp_pkg::req_type       item_data;
   logic                     out_free;
   logic                     advance;
   wavhp_pkg::rsp_type       step_result;
   wavhp_pkg::step_stat_type stat;

   logic               rsp_valid_ff, rsp_valid_in;
   wavhp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = item_valid && out_free;

   wavhp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   wavhp_step u_step (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (item_data),
      .result (step_result),
      .stat   (stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = stat.res_valid;
         if (stat.res_valid) begin
            rsp_data_in = step_result;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result always ends the parse
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      advance && stat.res_valid |=> stat.idle)
      else $error("parser not idle after a result");

   // data chunk fields are only filled by a successful parse
   a_data_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != wavhp_pkg::ST_OK
         |-> rsp_data.data_size == 32'd0 && rsp_data.data_offset == 32'd0)
      else $error("data fields set on a failed parse");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && stat.idle)
      else $error("result or busy parser right after reset");

endmodule

FILE: hdl/wavhp_in_stage.sv
module wavhp_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wavhp_pkg::req_type req_data,
   input  logic               advance,
   output logic               item_valid,
   output wavhp_pkg::req_type item_data
);

   logic               valid_ff, valid_in;
   wavhp_pkg::req_type data_ff, data_in;
   logic               load;

   assign req_ready  = !valid_ff || advance;
   assign load       = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

FILE: hdl/wavhp_step.sv
module wavhp_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  wavhp_pkg::req_type       item,
   output wavhp_pkg::rsp_type       result,
   output wavhp_pkg::step_stat_type stat
);

   wavhp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic [31:0] riff_ff, riff_in;
   logic [31:0] csize_ff, csize_in;
   logic [31:0] skip_ff, skip_in;
   wavhp_pkg::kind_type kind_ff, kind_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [31:0] doff_ff, doff_in;

   // state as seen by this item: a first mark starts from cleared state
   wavhp_pkg::phase_type b_phase;
   logic [31:0] b_pos, b_shift, b_riff, b_csize, b_skip;
   logic [2:0]  b_bidx;
   wavhp_pkg::kind_type b_kind;
   logic [15:0] b_fmt, b_chan, b_align, b_bits;
   logic [31:0] b_rate, b_brate, b_dsize, b_doff;

   logic        active;
   logic [31:0] v32;
   logic [15:0] v16;
   logic [2:0]  idx;
   logic [2:0]  need;
   logic        skip_req;
   logic [31:0] skip_n;
   logic [31:0] chunk_end;
   logic [32:0] body_end;
   logic        past_end;
   logic        ok, err;
   wavhp_pkg::status_type err_code, res_code;
   logic        res_valid;

   assign active = go && (item.first || phase_ff != wavhp_pkg::PH_IDLE);

   always_comb begin
      if (item.first) begin
         b_phase = wavhp_pkg::PH_RIFF_ID;
         b_pos   = '0;
         b_shift = '0;
         b_bidx  = '0;
         b_riff  = '0;
         b_csize = '0;
         b_skip  = '0;
         b_kind  = wavhp_pkg::KIND_OTHER;
         b_fmt   = '0;
         b_chan  = '0;
         b_rate  = '0;
         b_brate = '0;
         b_align = '0;
         b_bits  = '0;
         b_dsize = '0;
         b_doff  = '0;
      end else begin
         b_phase = phase_ff;
         b_pos   = pos_ff;
         b_shift = shift_ff;
         b_bidx  = bidx_ff;
         b_riff  = riff_ff;
         b_csize = csize_ff;
         b_skip  = skip_ff;
         b_kind  = kind_ff;
         b_fmt   = fmt_ff;
         b_chan  = chan_ff;
         b_rate  = rate_ff;
         b_brate = brate_ff;
         b_align = align_ff;
         b_bits  = bits_ff;
         b_dsize = dsize_ff;
         b_doff  = doff_ff;
      end
   end

   always_comb begin
      v32  = {item.byte_in, b_shift[31:8]};
      v16  = v32[31:16];
      idx  = b_bidx + 3'd1;
      need = wavhp_pkg::field_len(b_phase);

      phase_in = b_phase;
      pos_in   = b_pos + 32'd1;
      shift_in = v32;
      bidx_in  = b_bidx;
      riff_in  = b_riff;
      csize_in = b_csize;
      skip_in  = b_skip;
      kind_in  = b_kind;
      fmt_in   = b_fmt;
      chan_in  = b_chan;
      rate_in  = b_rate;
      brate_in = b_brate;
      align_in = b_align;
      bits_in  = b_bits;
      dsize_in = b_dsize;
      doff_in  = b_doff;

      ok       = 1'b0;
      err      = 1'b0;
      err_code = wavhp_pkg::ST_NO_DATA;
      skip_req = 1'b0;
      skip_n   = '0;

      if (b_phase == wavhp_pkg::PH_SKIP) begin
         skip_in = b_skip - 32'd1;
         if (skip_in == 32'd0) begin
            phase_in = wavhp_pkg::PH_CHUNK_ID;
         end
      end else if (idx < need) begin
         bidx_in = idx;
      end else begin
         bidx_in = '0;
         case (b_phase)
            wavhp_pkg::PH_RIFF_ID: begin
               if (v32 != wavhp_pkg::TAG_RIFF) begin
                  err      = 1'b1;
                  err_code = wavhp_pkg::ST_NO_RIFF;
               end else begin
                  phase_in = wavhp_pkg::PH_RIFF_SIZE;
               end
            end
            wavhp_pkg::PH_RIFF_SIZE: begin
               riff_in  = v32;
               phase_in = wavhp_pkg::PH_WAVE_ID;
            end
            wavhp_pkg::PH_WAVE_ID: begin
               if (v32 != wavhp_pkg::TAG_WAVE) begin
                  err      = 1'b1;
                  err_code = wavhp_pkg::ST_NO_WAVE;
               end else begin
                  phase_in = wavhp_pkg::PH_CHUNK_ID;
               end
            end
            wavhp_pkg::PH_CHUNK_ID: begin
               if (v32 == wavhp_pkg::TAG_FMT) begin
                  kind_in = wavhp_pkg::KIND_FMT;
               end else if (v32 == wavhp_pkg::TAG_DATA) begin
                  kind_in = wavhp_pkg::KIND_DATA;
               end else begin
                  kind_in = wavhp_pkg::KIND_OTHER;
               end
               phase_in = wavhp_pkg::PH_CHUNK_SZ;
            end
            wavhp_pkg::PH_CHUNK_SZ: begin
               csize_in = v32;
               if (b_kind == wavhp_pkg::KIND_DATA) begin
                  dsize_in = v32;
                  doff_in  = pos_in;
                  ok       = 1'b1;
               end else if (b_kind == wavhp_pkg::KIND_FMT) begin
                  phase_in = wavhp_pkg::PH_FMT_TAG;
               end else begin
                  skip_req = 1'b1;
                  skip_n   = v32;
               end
            end
            wavhp_pkg::PH_FMT_TAG: begin
               fmt_in = v16;
               if (v16 == wavhp_pkg::FMT_PCM || v16 == wavhp_pkg::FMT_EXT) begin
                  phase_in = wavhp_pkg::PH_CHANNELS;
               end else begin
                  skip_req = 1'b1;
                  // sizes below 2 end the chunk right after the tag
                  skip_n   = (b_csize < 32'd2) ? 32'd0 : b_csize - 32'd2;
               end
            end
            wavhp_pkg::PH_CHANNELS: begin
               chan_in  = v16;
               phase_in = wavhp_pkg::PH_RATE;
            end
            wavhp_pkg::PH_RATE: begin
               rate_in  = v32;
               phase_in = wavhp_pkg::PH_BYTERATE;
            end
            wavhp_pkg::PH_BYTERATE: begin
               brate_in = v32;
               phase_in = wavhp_pkg::PH_ALIGN;
            end
            wavhp_pkg::PH_ALIGN: begin
               align_in = v16;
               phase_in = wavhp_pkg::PH_BITS;
            end
            wavhp_pkg::PH_BITS: begin
               bits_in = v16;
               if (b_csize > wavhp_pkg::FMT_FIXED_LEN) begin
                  phase_in = wavhp_pkg::PH_CBSIZE;
               end else begin
                  skip_req = 1'b1;
               end
            end
            wavhp_pkg::PH_CBSIZE: begin
               skip_req = 1'b1;
               skip_n   = (v16 != 16'd0) ? wavhp_pkg::EXT_SKIP : 32'd0;
            end
            default: begin
            end
         endcase
      end

      // chunk end wraps at 32 bits, the body end does not
      chunk_end = b_pos + skip_n + 32'd1;
      body_end  = {1'b0, b_riff} + wavhp_pkg::RIFF_HDR_LEN;
      past_end  = {1'b0, chunk_end} >= body_end;

      if (skip_req) begin
         if (past_end) begin
            err      = 1'b1;
            err_code = wavhp_pkg::ST_NO_DATA;
         end else begin
            skip_in  = skip_n;
            phase_in = (skip_n == 32'd0) ? wavhp_pkg::PH_CHUNK_ID : wavhp_pkg::PH_SKIP;
         end
      end

      if (ok) begin
         res_code = wavhp_pkg::ST_OK;
      end else if (err) begin
         res_code = err_code;
      end else begin
         res_code = wavhp_pkg::ST_TRUNC;
      end
      res_valid = active && (ok || err || item.last);
      if (res_valid) begin
         phase_in = wavhp_pkg::PH_IDLE;
      end
   end

   always_comb begin
      result.status          = res_code;
      result.audio_format    = fmt_in;
      result.channels        = chan_in;
      result.sample_rate     = rate_in;
      result.byte_rate       = brate_in;
      result.block_align     = align_in;
      result.bits_per_sample = bits_in;
      result.data_size       = dsize_in;
      result.data_offset     = doff_in;
      result.riff_size       = riff_in;
      stat.idle              = (phase_ff == wavhp_pkg::PH_IDLE);
      stat.res_valid         = res_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wavhp_pkg::PH_IDLE;
      end else if (active) begin
         phase_ff <= phase_in;
      end
      if (active) begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         bidx_ff  <= bidx_in;
         riff_ff  <= riff_in;
         csize_ff <= csize_in;
         skip_ff  <= skip_in;
         kind_ff  <= kind_in;
         fmt_ff   <= fmt_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         brate_ff <= brate_in;
         align_ff <= align_in;
         bits_ff  <= bits_in;
         dsize_ff <= dsize_in;
         doff_ff  <= doff_in;
      end
   end

endmodule

FILE: dv/wav_header_parser_core_test.sv
`timescale 1ns / 100ps

module wav_header_parser_core_test;

   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   wavhp_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   wavhp_pkg::rsp_type rsp_data;

   wav_header_parser_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // parser state as predicted
   wavhp_pkg::phase_type m_phase;
   logic [31:0] m_pos;
   logic [31:0] m_shift;
   logic [2:0]  m_idx;
   logic [31:0] m_riff;
   logic [31:0] m_csize;
   logic [31:0] m_skip;
   wavhp_pkg::kind_type m_kind;
   logic [15:0] m_format;
   logic [15:0] m_channels;
   logic [31:0] m_rate;
   logic [31:0] m_byte_rate;
   logic [15:0] m_align;
   logic [15:0] m_bits;
   logic [31:0] m_data_size;
   logic [31:0] m_data_offset;
   bit          m_done;

   wavhp_pkg::rsp_type expected_headers[$];
   logic [7:0]         wav_bytes[$];
   wavhp_pkg::rsp_type want;

   bit steady = 1'b0;
   bit hold_rsp = 1'b0;
   int n_bytes = 0;
   int n_files = 0;
   int n_predicted = 0;
   int n_checked = 0;
   int n_errors = 0;
   int quiet_cycles = 0;
   int status_seen[5] = '{default: 0};

   function void clear_parse();
      m_phase = wavhp_pkg::PH_IDLE;
      m_pos = '0;
      m_shift = '0;
      m_idx = '0;
      m_riff = '0;
      m_csize = '0;
      m_skip = '0;
      m_kind = wavhp_pkg::KIND_OTHER;
      m_format = '0;
      m_channels = '0;
      m_rate = '0;
      m_byte_rate = '0;
      m_align = '0;
      m_bits = '0;
      m_data_size = '0;
      m_data_offset = '0;
      m_done = 1'b1;
   endfunction

   function void emit_header(wavhp_pkg::status_type st);
      wavhp_pkg::rsp_type r;
      r.status = st;
      r.audio_format = m_format;
      r.channels = m_channels;
      r.sample_rate = m_rate;
      r.byte_rate = m_byte_rate;
      r.block_align = m_align;
      r.bits_per_sample = m_bits;
      r.data_size = m_data_size;
      r.data_offset = m_data_offset;
      r.riff_size = m_riff;
      expected_headers.push_back(r);
      n_predicted++;
      m_done = 1'b1;
      m_phase = wavhp_pkg::PH_IDLE;
   endfunction

   // chunk ends n bytes from here; reaching the end of the RIFF body is an error (33-bit compare)
   function bit skip_overruns(logic [31:0] n);
      logic [31:0] chunk_end;
      chunk_end = m_pos + n;
      if ({1'b0, chunk_end} >= {1'b0, m_riff} + wavhp_pkg::RIFF_HDR_LEN) return 1'b1;
      m_skip = n;
      m_phase = (n == 0) ? wavhp_pkg::PH_CHUNK_ID : wavhp_pkg::PH_SKIP;
      return 1'b0;
   endfunction

   function void parse_byte(wavhp_pkg::req_type it);
      logic [2:0]  need;
      logic [2:0]  nidx;
      logic [31:0] v32;
      logic [15:0] v16;
      logic [31:0] fsize;
      bit          got_data;
      bit          fail;
      wavhp_pkg::status_type st;
      got_data = 1'b0;
      fail = 1'b0;
      st = wavhp_pkg::ST_OK;
      if (it.first) begin
         clear_parse();
         m_done = 1'b0;
         m_phase = wavhp_pkg::PH_RIFF_ID;
      end else if (m_done || m_phase == wavhp_pkg::PH_IDLE) begin
         return;
      end
      m_shift = {it.byte_in, m_shift[31:8]};
      m_pos = m_pos + 1;
      if (m_phase == wavhp_pkg::PH_SKIP) begin
         m_skip = m_skip - 1;
         if (m_skip == 0) m_phase = wavhp_pkg::PH_CHUNK_ID;
      end else begin
         case (m_phase)
            wavhp_pkg::PH_RIFF_ID, wavhp_pkg::PH_RIFF_SIZE, wavhp_pkg::PH_WAVE_ID,
            wavhp_pkg::PH_CHUNK_ID, wavhp_pkg::PH_CHUNK_SZ, wavhp_pkg::PH_RATE,
            wavhp_pkg::PH_BYTERATE: need = 3'd4;
            default:                need = 3'd2;
         endcase
         nidx = m_idx + 3'd1;
         if (nidx < need) begin
            m_idx = nidx;
         end else begin
            v32 = m_shift;
            v16 = m_shift[31:16];
            m_idx = '0;
            case (m_phase)
               wavhp_pkg::PH_RIFF_ID: begin
                  if (v32 != wavhp_pkg::TAG_RIFF) begin
                     fail = 1'b1;
                     st = wavhp_pkg::ST_NO_RIFF;
                  end else m_phase = wavhp_pkg::PH_RIFF_SIZE;
               end
               wavhp_pkg::PH_RIFF_SIZE: begin
                  m_riff = v32;
                  m_phase = wavhp_pkg::PH_WAVE_ID;
               end
               wavhp_pkg::PH_WAVE_ID: begin
                  if (v32 != wavhp_pkg::TAG_WAVE) begin
                     fail = 1'b1;
                     st = wavhp_pkg::ST_NO_WAVE;
                  end else m_phase = wavhp_pkg::PH_CHUNK_ID;
               end
               wavhp_pkg::PH_CHUNK_ID: begin
                  m_kind = (v32 == wavhp_pkg::TAG_FMT) ? wavhp_pkg::KIND_FMT :
                           (v32 == wavhp_pkg::TAG_DATA) ? wavhp_pkg::KIND_DATA :
                           wavhp_pkg::KIND_OTHER;
                  m_phase = wavhp_pkg::PH_CHUNK_SZ;
               end
               wavhp_pkg::PH_CHUNK_SZ: begin
                  m_csize = v32;
                  if (m_kind == wavhp_pkg::KIND_DATA) begin
                     m_data_size = v32;
                     m_data_offset = m_pos;
                     got_data = 1'b1;
                  end else if (m_kind == wavhp_pkg::KIND_FMT) begin
                     m_phase = wavhp_pkg::PH_FMT_TAG;
                  end else if (skip_overruns(v32)) begin
                     fail = 1'b1;
                     st = wavhp_pkg::ST_NO_DATA;
                  end
               end
               wavhp_pkg::PH_FMT_TAG: begin
                  m_format = v16;
                  if (v16 == wavhp_pkg::FMT_PCM || v16 == wavhp_pkg::FMT_EXT) begin
                     m_phase = wavhp_pkg::PH_CHANNELS;
                  end else begin
                     // a tag-only fmt chunk still covers the tag itself
                     fsize = (m_csize < 2) ? 32'd2 : m_csize;
                     if (skip_overruns(fsize - 2)) begin
                        fail = 1'b1;
                        st = wavhp_pkg::ST_NO_DATA;
                     end
                  end
               end
               wavhp_pkg::PH_CHANNELS: begin
                  m_channels = v16;
                  m_phase = wavhp_pkg::PH_RATE;
               end
               wavhp_pkg::PH_RATE: begin
                  m_rate = v32;
                  m_phase = wavhp_pkg::PH_BYTERATE;
               end
               wavhp_pkg::PH_BYTERATE: begin
                  m_byte_rate = v32;
                  m_phase = wavhp_pkg::PH_ALIGN;
               end
               wavhp_pkg::PH_ALIGN: begin
                  m_align = v16;
                  m_phase = wavhp_pkg::PH_BITS;
               end
               wavhp_pkg::PH_BITS: begin
                  m_bits = v16;
                  if (m_csize > wavhp_pkg::FMT_FIXED_LEN) begin
                     m_phase = wavhp_pkg::PH_CBSIZE;
                  end else if (skip_overruns(32'd0)) begin
                     fail = 1'b1;
                     st = wavhp_pkg::ST_NO_DATA;
                  end
               end
               wavhp_pkg::PH_CBSIZE: begin
                  if (skip_overruns((v16 != 0) ? wavhp_pkg::EXT_SKIP : 32'd0)) begin
                     fail = 1'b1;
                     st = wavhp_pkg::ST_NO_DATA;
                  end
               end
               default: ;
            endcase
         end
      end
      if (got_data) emit_header(wavhp_pkg::ST_OK);
      else if (fail) emit_header(st);
      else if (it.last) emit_header(wavhp_pkg::ST_TRUNC);
   endfunction

   function void check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_headers.size() == 0) begin
            $error("status: expected no item, got %0d", rsp_data.status);
            n_errors++;
         end else begin
            want = expected_headers.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("audio_format", 32'(want.audio_format),
                        32'(rsp_data.audio_format));
            check_field("channels", 32'(want.channels), 32'(rsp_data.channels));
            check_field("sample_rate", want.sample_rate, rsp_data.sample_rate);
            check_field("byte_rate", want.byte_rate, rsp_data.byte_rate);
            check_field("block_align", 32'(want.block_align),
                        32'(rsp_data.block_align));
            check_field("bits_per_sample", 32'(want.bits_per_sample),
                        32'(rsp_data.bits_per_sample));
            check_field("data_size", want.data_size, rsp_data.data_size);
            check_field("data_offset", want.data_offset, rsp_data.data_offset);
            check_field("riff_size", want.riff_size, rsp_data.riff_size);
            n_checked++;
            if (want.status < 5) status_seen[want.status]++;
         end
      end
   end

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("wav_header_parser_core test failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
      wavhp_pkg::req_type it;
      it.byte_in = b;
      it.first = first;
      it.last = last;
      if (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(0, 99) < 34);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      parse_byte(it);
      n_bytes++;
   endtask

   task automatic send_file(input int len, input bit mark_last);
      for (int i = 0; i < len; i++) begin
         send_byte(wav_bytes[i], i == 0, mark_last && (i == len - 1));
      end
      n_files++;
   endtask

   function void put16(logic [15:0] v);
      wav_bytes.push_back(v[7:0]);
      wav_bytes.push_back(v[15:8]);
   endfunction

   function void put32(logic [31:0] v);
      put16(v[15:0]);
      put16(v[31:16]);
   endfunction

   function void put_random(int n);
      repeat (n) wav_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function void put_chunk_hdr(logic [31:0] tag, logic [31:0] size);
      put32(tag);
      put32(size);
   endfunction

   function void start_file(logic [31:0] riff);
      wav_bytes.delete();
      put_chunk_hdr(wavhp_pkg::TAG_RIFF, riff);
      put32(wavhp_pkg::TAG_WAVE);
   endfunction

   function void put_fmt(logic [31:0] size, logic [15:0] tag, logic [15:0] chans,
                         logic [31:0] rate, logic [31:0] brate, logic [15:0] align,
                         logic [15:0] bits);
      put_chunk_hdr(wavhp_pkg::TAG_FMT, size);
      put16(tag);
      put16(chans);
      put32(rate);
      put32(brate);
      put16(align);
      put16(bits);
   endfunction

   function automatic logic [31:0] rnd32();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rnd16();
      case ($urandom_range(0, 5))
         0:       return 16'h0;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic send_random_file();
      int          size;
      int          len;
      int          k;
      logic [15:0] cb;
      logic [31:0] riff;
      start_file(32'd0);
      repeat ($urandom_range(0, 3)) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            case ($urandom_range(0, 3))
               0:       size = 16;
               1:       size = 18;
               2:       size = 40;
               default: size = $urandom_range(0, 20);
            endcase
            put_fmt(size, $urandom_range(0, 1) ? wavhp_pkg::FMT_PCM : wavhp_pkg::FMT_EXT,
                    rnd16(), rnd32(), rnd32(), rnd16(), rnd16());
            if (size > 16) begin
               if ($urandom_range(0, 2) == 0) cb = 16'd0;
               else cb = $urandom_range(0, 1) ? 16'd22 : rnd16();
               put16(cb);
               if (cb != 0) put_random(22);
            end
         end else if (k < 7) begin
            size = $urandom_range(0, 8);
            put_chunk_hdr(wavhp_pkg::TAG_FMT, size);
            put16(16'($urandom_range(2, 16'hFFFD)));
            if (size > 2) put_random(size - 2);
         end else begin
            size = $urandom_range(0, 8);
            put_chunk_hdr($urandom, size);
            put_random(size);
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         put_chunk_hdr(wavhp_pkg::TAG_DATA, rnd32());
         put_random($urandom_range(0, 3));
      end
      case ($urandom_range(0, 19))
         0, 1, 2: riff = $urandom_range(0, 40);
         3, 4:    riff = $urandom;
         5:       riff = 32'hFFFF_FFFF;
         default: riff = wav_bytes.size() - 8 + $urandom_range(0, 4);
      endcase
      for (int i = 0; i < 4; i++) wav_bytes[4 + i] = riff[8*i +: 8];
      // occasionally corrupt a tag or the size
      if ($urandom_range(0, 11) == 0) begin
         k = $urandom_range(0, 11);
         wav_bytes[k] = wav_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
      end
      len = wav_bytes.size();
      case ($urandom_range(0, 19))
         0, 1, 2: send_file($urandom_range(1, len), 1'b1);
         3, 4:    send_file($urandom_range(1, len), 1'b0);
         default: send_file(len, 1'b1);
      endcase
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0,
                                                 1'($urandom_range(0, 1)));
      end
   endtask

   // bytes with no first mark after reset are dropped
   task automatic test_ignored_bytes();
      send_byte(8'h52, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b0, 1'b1);
   endtask

   task automatic test_directed_headers();
      // plain PCM, trailing sample bytes ignored
      start_file(32'd36);
      put_fmt(32'd16, wavhp_pkg::FMT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'h100);
      put16(16'h1234);
      send_file(wav_bytes.size(), 1'b1);
      // all-ones fields, extension skipped
      start_file(32'hFFFF_FFFF);
      put_fmt(32'hFFFF_FFFF, wavhp_pkg::FMT_EXT, '1, '1, '1, '1, '1);
      put16(16'hFFFF);
      repeat (22) wav_bytes.push_back(8'hFF);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'hFFFF_FFFF);
      send_file(wav_bytes.size(), 1'b1);
      // extensible, size 40
      start_file(32'd68);
      put_fmt(32'd40, wavhp_pkg::FMT_EXT, 16'd6, 32'd48000, 32'd576000, 16'd12, 16'd16);
      put16(16'd22);
      put_random(22);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'd0);
      send_file(wav_bytes.size(), 1'b1);
      // size 18 with zero cbSize
      start_file(32'd46);
      put_fmt(32'd18, wavhp_pkg::FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
      put16(16'd0);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'd77);
      send_file(wav_bytes.size(), 1'b1);
      // short size still reads the fixed fields
      start_file(32'd36);
      put_fmt(32'd4, wavhp_pkg::FMT_PCM, 16'd2, 32'd22050, 32'd88200, 16'd4, 16'd16);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'd5);
      send_file(wav_bytes.size(), 1'b1);
      // non-PCM fmt with size 0, data follows the tag
      start_file(32'd22);
      put_chunk_hdr(wavhp_pkg::TAG_FMT, 32'd0);
      put16(16'h0003);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'd9);
      send_file(wav_bytes.size(), 1'b1);
      // PCM, then non-PCM with odd size, then odd-sized unknown chunk
      start_file(32'd60);
      put_fmt(32'd16, wavhp_pkg::FMT_PCM, 16'd2, 32'd96000, 32'd768000, 16'd8, 16'd32);
      put_chunk_hdr(wavhp_pkg::TAG_FMT, 32'd5);
      put16(16'h0002);
      put_random(3);
      put_chunk_hdr(32'h5453_494C, 32'd3);
      put_random(3);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'd1);
      send_file(wav_bytes.size(), 1'b1);
      // bad RIFF tag, bad WAVE tag
      wav_bytes.delete();
      put32(32'h5846_4952);
      send_file(4, 1'b0);
      wav_bytes.delete();
      put_chunk_hdr(wavhp_pkg::TAG_RIFF, 32'd100);
      put32(32'h4656_4157);
      send_file(12, 1'b0);
      // first chunk past a tiny RIFF size
      start_file(32'd4);
      put_chunk_hdr(32'h5453_494C, 32'd0);
      send_file(wav_bytes.size(), 1'b0);
      // fmt fills the body exactly, no room for data
      start_file(32'd28);
      put_fmt(32'd16, wavhp_pkg::FMT_PCM, 16'd1, 32'd1, 32'd1, 16'd1, 16'd1);
      send_file(wav_bytes.size(), 1'b0);
      // extension would run past the body
      start_file(32'd30);
      put_fmt(32'd18, wavhp_pkg::FMT_PCM, 16'd1, 32'd1, 32'd1, 16'd1, 16'd1);
      put16(16'd5);
      send_file(wav_bytes.size(), 1'b0);
      // chunk end one short of riff + 8 at 33 bits, then truncated
      start_file(32'hFFFF_FFF8);
      put_chunk_hdr(32'h5453_494C, 32'hFFFF_FFEB);
      put_random(3);
      send_file(wav_bytes.size(), 1'b1);
      // chunk end equal to riff + 8
      start_file(32'hFFFF_FFF7);
      put_chunk_hdr(32'h5453_494C, 32'hFFFF_FFEB);
      send_file(wav_bytes.size(), 1'b0);
      // chunk end wraps past 2^32
      start_file(32'd16);
      put_chunk_hdr(32'h5453_494C, 32'hFFFF_FFF0);
      put_random(2);
      send_file(wav_bytes.size(), 1'b1);
      // truncated inside fmt, then restart in mid-parse
      start_file(32'd36);
      put_fmt(32'd16, wavhp_pkg::FMT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
      put_chunk_hdr(wavhp_pkg::TAG_DATA, 32'h40);
      send_file(27, 1'b1);
      send_file(30, 1'b0);
      send_file(wav_bytes.size(), 1'b1);
   endtask

   // receiver holds off while short bad files keep coming
   task automatic test_result_stall();
      steady = 1'b1;
      hold_rsp = 1'b1;
      repeat (24) begin
         wav_bytes.delete();
         put32(wavhp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
         send_file(4, 1'b0);
      end
      steady = 1'b0;
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (12) send_random_file();
      steady = 1'b0;
   endtask

   task automatic test_random_files();
      while (n_bytes < 1250) send_random_file();
   endtask

   initial begin
      clear_parse();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_ignored_bytes();
      test_directed_headers();
      test_result_stall();
      test_back_to_back();
      test_random_files();
      req_valid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Fed %0d files, %0d bytes; %0d headers compared", n_files, n_bytes,
               n_checked);
      $display("Outcomes: ok %0d, no RIFF %0d, no WAVE %0d, no data %0d, truncated %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (n_errors == 0) begin
         $display("wav_header_parser_core test passed");
      end else begin
         $display("wav_header_parser_core test failed");
      end
      $finish;
   end

endmodule
